@@ rtl/core/sdrfr_pkg.sv @@
// Shared types and constants of the I/Q datagram framer.
package sdrfr_pkg;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int SAMPLE_W    = 48;
	localparam int SEQ_W       = 32;
	localparam int STEP_W      = 3;
	localparam int SIS_W       = 5;
	localparam int BIDX_W      = 4;
	localparam int QDEPTH      = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_STEP0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP4 = 3'd4;

	localparam logic [CFG_DATA_W-1:0] RST_STEP0 = 32'h0021_1115;
	localparam logic [CFG_DATA_W-1:0] RST_STEP4 = 32'h4242_4242;

	// control steps
	localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

	// fixed datagram bytes
	localparam logic [7:0] ID_BYTE0  = 8'hef;
	localparam logic [7:0] ID_BYTE1  = 8'hfe;
	localparam logic [7:0] ID_BYTE2  = 8'h01;
	localparam logic [7:0] ID_BYTE3  = 8'h06;
	localparam logic [7:0] SYNC_BYTE = 8'h7f;

	// byte positions inside each section
	localparam logic [BIDX_W-1:0] HDR_LAST  = 4'd7;
	localparam logic [BIDX_W-1:0] CTRL_LAST = 4'd7;
	localparam logic [BIDX_W-1:0] MIC_LAST  = 4'd1;
	localparam logic [BIDX_W-1:0] PAD_LAST  = 4'd9;
	localparam logic [2:0]        SBYTE_LAST = 3'd5;

	// one accepted sample, classified by the front part
	typedef struct packed {
		logic [SAMPLE_W-1:0]   sample;
		logic [SEQ_W-1:0]      seq;
		logic [STEP_W-1:0]     step;
		logic [CFG_DATA_W-1:0] payload;
		logic                  has_hdr;
		logic                  has_ctrl;
		logic                  has_pad;
		logic                  ends_dg;
	} job_t;

	// emission phase of the back part
	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_HDR  = 6'b000010,
		PH_CTRL = 6'b000100,
		PH_SAMP = 6'b001000,
		PH_MIC  = 6'b010000,
		PH_PAD  = 6'b100000
	} phase_t;

endpackage

@@ rtl/core/sdrfr_front.sv @@
// Front part: accepts samples, tracks framing position and builds jobs.
module sdrfr_front
	import sdrfr_pkg::*;
#(
	parameter int SAMPLES_PER_SUBFRAME = 19
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [SAMPLE_W-1:0]   iq_sample_bytes,
	output job_t                  job
);

	logic [CFG_DATA_W-1:0] pay0_q, pay1_q, pay2_q, pay3_q, pay4_q;
	logic [SEQ_W-1:0]      seq_q;
	logic [STEP_W-1:0]     step_q;
	logic [SIS_W-1:0]      sis_q;
	logic                  sf_q;
	logic                  first_s;
	logic                  last_s;
	logic [CFG_DATA_W-1:0] pay_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay0_q <= RST_STEP0;
			pay1_q <= '0;
			pay2_q <= '0;
			pay3_q <= '0;
			pay4_q <= RST_STEP4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP0: pay0_q <= cfg_data;
				CFG_STEP1: pay1_q <= cfg_data;
				CFG_STEP2: pay2_q <= cfg_data;
				CFG_STEP3: pay3_q <= cfg_data;
				CFG_STEP4: pay4_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (step_q)
			CFG_STEP0: pay_sel = pay0_q;
			CFG_STEP1: pay_sel = pay1_q;
			CFG_STEP2: pay_sel = pay2_q;
			CFG_STEP3: pay_sel = pay3_q;
			default:   pay_sel = pay4_q;
		endcase
	end

	assign first_s = (sis_q == '0);
	// out-of-range counter counts as last sample too
	assign last_s  = ({1'b0, sis_q} + (SIS_W+1)'(1)) >= (SIS_W+1)'(SAMPLES_PER_SUBFRAME);

	always_comb begin
		job.sample   = iq_sample_bytes;
		job.seq      = seq_q;
		job.step     = step_q;
		job.payload  = pay_sel;
		job.has_hdr  = first_s && !sf_q;
		job.has_ctrl = first_s;
		job.has_pad  = last_s;
		job.ends_dg  = last_s && sf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			step_q <= '0;
			sis_q  <= '0;
			sf_q   <= 1'b0;
		end else if (accept) begin
			if (first_s) begin
				if (!sf_q) begin
					seq_q <= seq_q + SEQ_W'(1);
				end
				step_q <= (step_q < STEP_LAST) ? step_q + STEP_W'(1) : '0;
			end
			if (last_s) begin
				sis_q <= '0;
				sf_q  <= !sf_q;
			end else begin
				sis_q <= sis_q + SIS_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/sdrfr_jobq.sv @@
// Short job queue between the front and back parts.
module sdrfr_jobq
	import sdrfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	output logic q_full,
	input  logic rd,
	output logic q_empty,
	output job_t rd_job
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	job_t             slot_q [QDEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_full  = (cnt_q == CNT_W'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_job  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PTR_W'(QDEPTH-1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == PTR_W'(QDEPTH-1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/sdrfr_back.sv @@
// Back part: walks a job one datagram byte per cycle into the output register while that register is free or popped.
module sdrfr_back
	import sdrfr_pkg::*;
#(
	parameter int RECEIVER_COPIES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       hd,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       datagram_end
);

	localparam int CP_W = (RECEIVER_COPIES > 1) ? $clog2(RECEIVER_COPIES) : 1;

	phase_t            phase_q, cur, nxt;
	logic [BIDX_W-1:0] idx_q;
	logic [2:0]        k_q;
	logic [CP_W-1:0]   cp_q;
	logic              fire;
	logic              done;
	logic [7:0]        byte_c;
	logic [7:0]        seq_b, pay_b, smp_b;
	logic              out_v_q;

	always_comb begin
		if (phase_q == PH_IDLE) begin
			cur = hd.has_hdr ? PH_HDR : (hd.has_ctrl ? PH_CTRL : PH_SAMP);
		end else begin
			cur = phase_q;
		end
	end

	assign fire = !q_empty && (!out_v_q || pop);

	always_comb begin
		case (idx_q[1:0])
			2'd0:    seq_b = hd.seq[31:24];
			2'd1:    seq_b = hd.seq[23:16];
			2'd2:    seq_b = hd.seq[15:8];
			default: seq_b = hd.seq[7:0];
		endcase
		case (idx_q[1:0])
			2'd0:    pay_b = hd.payload[31:24];
			2'd1:    pay_b = hd.payload[23:16];
			2'd2:    pay_b = hd.payload[15:8];
			default: pay_b = hd.payload[7:0];
		endcase
		case (k_q)
			3'd0:    smp_b = hd.sample[47:40];
			3'd1:    smp_b = hd.sample[39:32];
			3'd2:    smp_b = hd.sample[31:24];
			3'd3:    smp_b = hd.sample[23:16];
			3'd4:    smp_b = hd.sample[15:8];
			3'd5:    smp_b = hd.sample[7:0];
			default: smp_b = '0;
		endcase
	end

	always_comb begin
		byte_c = '0;
		unique case (cur)
			PH_HDR: begin
				if (idx_q[2]) begin
					byte_c = seq_b;
				end else begin
					case (idx_q[1:0])
						2'd0:    byte_c = ID_BYTE0;
						2'd1:    byte_c = ID_BYTE1;
						2'd2:    byte_c = ID_BYTE2;
						default: byte_c = ID_BYTE3;
					endcase
				end
			end
			PH_CTRL: begin
				if (idx_q[2]) begin
					byte_c = pay_b;
				end else if (idx_q[1:0] == 2'd3) begin
					byte_c = {2'b00, hd.step, 3'b000};
				end else begin
					byte_c = SYNC_BYTE;
				end
			end
			PH_SAMP: byte_c = smp_b;
			default: byte_c = '0;
		endcase
	end

	always_comb begin
		done = 1'b0;
		nxt  = cur;
		unique case (cur)
			PH_HDR:  if (idx_q == HDR_LAST) nxt = PH_CTRL;
			PH_CTRL: if (idx_q == CTRL_LAST) nxt = PH_SAMP;
			PH_SAMP: if (k_q == SBYTE_LAST && cp_q == CP_W'(RECEIVER_COPIES-1)) nxt = PH_MIC;
			PH_MIC: begin
				if (idx_q == MIC_LAST) begin
					if (hd.has_pad) begin
						nxt = PH_PAD;
					end else begin
						nxt  = PH_IDLE;
						done = 1'b1;
					end
				end
			end
			PH_PAD: begin
				if (idx_q == PAD_LAST) begin
					nxt  = PH_IDLE;
					done = 1'b1;
				end
			end
			default: nxt = PH_IDLE;
		endcase
	end

	assign q_pop = fire && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			k_q     <= '0;
			cp_q    <= '0;
		end else if (fire) begin
			phase_q <= nxt;
			if (nxt != cur) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + BIDX_W'(1);
			end
			if (cur == PH_SAMP) begin
				if (k_q == SBYTE_LAST) begin
					k_q  <= '0;
					cp_q <= (cp_q == CP_W'(RECEIVER_COPIES-1)) ? '0 : cp_q + CP_W'(1);
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte     <= byte_c;
			last_of_run  <= done;
			datagram_end <= done && hd.ends_dg;
		end
	end

	assign empty = !out_v_q;

endmodule

@@ rtl/core/sdr_iq_datagram_framer_unit.sv @@
// Top level of the I/Q datagram framer: front, job queue and byte emitter.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   sample   | push / full        | iq_sample_bytes[47:0]
//   result   | pop / empty        | out_byte[7:0], last_of_run, datagram_end
//   config   | cfg_we (no wait)   | cfg_index[2:0], cfg_data[31:0]
//
// The byte emitter sends one datagram byte per clock while results are taken.
// A plain sample gives its sample copies and mic bytes; opening sub-frame 1 adds
// control, opening a datagram adds header and control, a sub-frame's last pads.
// With the emitter idle, an accepted item is written into the job queue and its
// first byte then passes through the output register to the result ports.
// Reset clears the framing position, sequence count, queue and output valid
// flag and loads the control payload registers with their defaults.
// A stalled result holds the emitter; the two-entry job queue keeps taking
// samples until it fills, then full rises.
module sdr_iq_datagram_framer_unit
	import sdrfr_pkg::*;
#(
	parameter int SAMPLES_PER_SUBFRAME = 19,
	parameter int RECEIVER_COPIES      = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample side
	input  logic                  push,
	output logic                  full,
	input  logic [SAMPLE_W-1:0]   iq_sample_bytes,
	// result side
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            out_byte,
	output logic                  last_of_run,
	output logic                  datagram_end,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	job_t new_job;
	job_t head_job;
	logic accept;
	logic q_full;
	logic q_empty;
	logic q_pop;

	// take an item only while the job queue has room
	assign accept = push && !q_full;
	assign full   = q_full;

	// classify the item and advance sequence count, control step and position
	sdrfr_front #(
		.SAMPLES_PER_SUBFRAME(SAMPLES_PER_SUBFRAME)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.iq_sample_bytes(iq_sample_bytes),
		.job            (new_job)
	);

	// decouple classification from emission
	sdrfr_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_job (new_job),
		.q_full (q_full),
		.rd     (q_pop),
		.q_empty(q_empty),
		.rd_job (head_job)
	);

	// emit header, control, sample copies, mic and padding bytes in order;
	// drop the job from the queue on its final byte
	sdrfr_back #(
		.RECEIVER_COPIES(RECEIVER_COPIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.hd          (head_job),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.datagram_end(datagram_end)
	);

endmodule

@@ rtl/core/sdrfr_checker.sv @@
// Port-level checks of the I/Q datagram framer, bound to the top level.
module sdrfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last_of_run,
	input logic       datagram_end
);

	// a datagram closes only on the final byte of an item
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && datagram_end) |-> last_of_run)
		else $error("datagram_end without last_of_run");

	// an item always finishes on a mic or padding byte, both zero
	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_run) |-> (out_byte == 8'h00))
		else $error("final byte of an item is not zero");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)
			&& $stable(datagram_end)))
		else $error("waiting result changed");

	// nothing comes out of a block that has never taken an item
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !$past(push) && !$past(push, 2) && $past(empty) && $past(empty, 2)
			&& $past(arst_n, 2) && !full) |=> empty)
		else $error("result appeared without an item");

endmodule

bind sdr_iq_datagram_framer_unit sdrfr_checker u_chk (.*);
